[rtl/core/afrg_pkg.sv]
// ----------------------------------------------------------------------------
// afrg_pkg
// Shared types and constants for the additive feedback random generator.
// ----------------------------------------------------------------------------
package afrg_pkg;

  // Input operation codes, carried on tuser
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  // Generator types
  localparam logic [2:0] TYPE_LCG = 3'd0;
  localparam logic [2:0] TYPE_MAX = 3'd4;

  // Arithmetic constants
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [14:0] FILL_MUL = 15'd16807;
  localparam logic [31:0] MOD_P    = 32'h7fff_ffff;
  localparam logic [31:0] SEED_ONE = 32'd1;

  // Discarded draws per table word after a reseed
  localparam int unsigned DISCARD_FACTOR = 10;

  // Control from the sequencer to the arithmetic unit
  typedef struct packed {
    logic mul_en;   // load product register
    logic sel_lcg;  // multiply read word by LCG constant
    logic fwd_a;    // front operand taken from last write
    logic fwd_b;    // rear operand taken from last write
  } arith_ctrl_t;

  // Table degree per type; out-of-range types act as the largest
  function automatic logic [5:0] deg_of(input logic [2:0] t);
    logic [5:0] d;
    case (t)
      3'd0:    d = 6'd0;
      3'd1:    d = 6'd7;
      3'd2:    d = 6'd15;
      3'd3:    d = 6'd31;
      default: d = 6'd63;
    endcase
    return d;
  endfunction

  // Separation between front and rear per type
  function automatic logic [1:0] sep_of(input logic [2:0] t);
    logic [1:0] s;
    case (t)
      3'd0:    s = 2'd0;
      3'd1:    s = 2'd3;
      3'd2:    s = 2'd1;
      3'd3:    s = 2'd3;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/afrg_lag_ram.sv]
// ----------------------------------------------------------------------------
// afrg_lag_ram
// Lag table store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module afrg_lag_ram #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [31:0]   rdata_a_o,
  output logic [31:0]   rdata_b_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Reads return the old word on a same-cycle write; the sequencer forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[rtl/core/afrg_arith.sv]
// ----------------------------------------------------------------------------
// afrg_arith
// Shared multiplier with product register, mod (2^31-1) fold, LCG increment
// and the lagged add with write forwarding.
// ----------------------------------------------------------------------------
module afrg_arith (
  input  logic                  clk_i,
  input  afrg_pkg::arith_ctrl_t ctrl_i,
  input  logic [31:0]           fill_val_i,
  input  logic [31:0]           rdata_a_i,
  input  logic [31:0]           rdata_b_i,
  input  logic [31:0]           fwd_data_i,
  output logic [31:0]           fold_o,
  output logic [30:0]           lcg_o,
  output logic [31:0]           sum_o
);
  import afrg_pkg::*;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [46:0] prod_q;
  logic [31:0] fold_raw;
  logic [31:0] lcg_sum;
  logic [31:0] op_a;
  logic [31:0] op_b;

  assign mul_a = ctrl_i.sel_lcg ? rdata_a_i : fill_val_i;
  assign mul_b = ctrl_i.sel_lcg ? LCG_MUL : {17'd0, FILL_MUL};
  assign prod  = 64'(mul_a) * 64'(mul_b);

  // 47 bits hold the fill product; the LCG needs only the low word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod[46:0];
    end
  end

  // 2^31 == 1 mod P, so hi + lo stays below 2P: one subtract suffices
  assign fold_raw = {1'b0, prod_q[30:0]} + {16'd0, prod_q[46:31]};
  assign fold_o   = (fold_raw >= MOD_P) ? (fold_raw - MOD_P) : fold_raw;

  assign lcg_sum = prod_q[31:0] + LCG_INC;
  assign lcg_o   = lcg_sum[30:0];

  assign op_a  = ctrl_i.fwd_a ? fwd_data_i : rdata_a_i;
  assign op_b  = ctrl_i.fwd_b ? fwd_data_i : rdata_b_i;
  assign sum_o = op_a + op_b;

endmodule

[rtl/core/additive_feedback_random_generator.sv]
// ----------------------------------------------------------------------------
// additive_feedback_random_generator
// Additive lagged-feedback random generator with an LCG mode, state held in
// a two-read one-write lag table.
// ----------------------------------------------------------------------------
//  channel   dir  signals                        content
//  s_axis    in   tvalid/tready/tdata/tuser      tuser: func, tdata: seed
//  m_axis    out  tvalid/tready/tdata            tdata[30:0]: random_value
//  cfg       in   cfg_we_i/cfg_wdata_i           table_type
//
//  An additive draw reads, then adds and writes back; type 0 reads, multiplies
//  and adds. A reseed writes the seed word, then one multiply-fold pair per
//  further table word, then 10*degree discard draws at one per cycle through
//  the table ports. A type 0 reseed writes only the seed word. The first word
//  after reset is preceded by a seed-one reseed. A draw waits in its last step
//  while the output word is unconsumed; tready is high only between words.
// ----------------------------------------------------------------------------
module additive_feedback_random_generator #(
  parameter int unsigned MAX_DEGREE = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] seed
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [30:0] random_value, [31] zero
);
  import afrg_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DEGREE);
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned CW = $clog2(DISCARD_FACTOR * MAX_DEGREE + 1);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SEED    = 11'b000_0000_0010,
    ST_MUL     = 11'b000_0000_0100,
    ST_FOLD    = 11'b000_0000_1000,
    ST_DISC    = 11'b000_0001_0000,
    ST_FIN     = 11'b000_0010_0000,
    ST_DRAW_RD = 11'b000_0100_0000,
    ST_DRAW_WR = 11'b000_1000_0000,
    ST_LCG_RD  = 11'b001_0000_0000,
    ST_LCG_MUL = 11'b010_0000_0000,
    ST_LCG_ADD = 11'b100_0000_0000
  } state_e;

  function automatic logic [DW-1:0] deg_lim(input logic [2:0] t);
    logic [5:0] raw;
    raw = deg_of(t);
    if (int'(raw) > int'(MAX_DEGREE)) begin
      return DW'(MAX_DEGREE);
    end
    return DW'(raw);
  endfunction

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx,
                                            input logic [DW-1:0] deg);
    if (DW'(idx) == deg - DW'(1)) begin
      return '0;
    end
    return idx + AW'(1);
  endfunction

  state_e state_q, state_d;
  logic [2:0]    table_type_q, table_type_d;
  logic [2:0]    act_q, act_d;
  logic          seeded_q, seeded_d;
  logic          pend_q, pend_d;
  logic          func_q, func_d;
  logic [31:0]   seed_q, seed_d;
  logic [31:0]   fill_val_q, fill_val_d;
  logic [AW-1:0] fill_idx_q, fill_idx_d;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] rear_q, rear_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [CW-1:0] disc_q, disc_d;
  logic          rd_pend_q, rd_pend_d;
  logic          fwd_a_q, fwd_a_d;
  logic          fwd_b_q, fwd_b_d;
  logic [31:0]   fwd_data_q, fwd_data_d;
  logic          m_valid_q, m_valid_d;
  logic [30:0]   m_data_q, m_data_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr_a;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  arith_ctrl_t   actl;
  logic [31:0]   fold_val;
  logic [30:0]   lcg_val;
  logic [31:0]   sum_val;

  logic          out_free;
  logic          issue;
  logic          complete;
  logic [31:0]   seed_sel;
  logic [31:0]   seed_fix;
  logic [DW-1:0] deg;
  logic [1:0]    sep;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign deg      = deg_lim(act_q);
  assign sep      = sep_of(act_q);
  assign seed_sel = pend_q ? SEED_ONE : seed_q;
  assign seed_fix = (seed_sel == 32'd0) ? SEED_ONE : seed_sel;

  always_comb begin
    state_d      = state_q;
    table_type_d = cfg_we_i ? cfg_wdata_i : table_type_q;
    act_d        = act_q;
    seeded_d     = seeded_q;
    pend_d       = pend_q;
    func_d       = func_q;
    seed_d       = seed_q;
    fill_val_d   = fill_val_q;
    fill_idx_d   = fill_idx_q;
    front_d      = front_q;
    rear_d       = rear_q;
    wr_addr_d    = wr_addr_q;
    disc_d       = disc_q;
    rd_pend_d    = rd_pend_q;
    fwd_a_d      = fwd_a_q;
    fwd_b_d      = fwd_b_q;
    fwd_data_d   = fwd_data_q;
    m_valid_d    = m_axis_tready_i ? 1'b0 : m_valid_q;
    m_data_d     = m_data_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr_a  = front_q;
    issue        = 1'b0;
    complete     = 1'b0;
    actl         = '{mul_en: 1'b0, sel_lcg: 1'b0, fwd_a: fwd_a_q, fwd_b: fwd_b_q};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          func_d   = s_axis_tuser_i;
          seed_d   = s_axis_tdata_i;
          seeded_d = 1'b1;
          if (!seeded_q) begin
            pend_d  = 1'b1;
            state_d = ST_SEED;
          end else if (s_axis_tuser_i == FUNC_RESEED) begin
            state_d = ST_SEED;
          end else if (act_q == TYPE_LCG) begin
            state_d = ST_LCG_RD;
          end else begin
            state_d = ST_DRAW_RD;
          end
        end
      end
      ST_SEED: begin
        ram_we     = 1'b1;
        ram_wdata  = seed_fix;
        fill_val_d = seed_fix;
        fill_idx_d = AW'(1);
        act_d      = (table_type_q > TYPE_MAX) ? TYPE_MAX : table_type_q;
        state_d    = (act_d == TYPE_LCG) ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        actl.mul_en = 1'b1;
        state_d     = ST_FOLD;
      end
      ST_FOLD: begin
        ram_we     = 1'b1;
        ram_waddr  = fill_idx_q;
        ram_wdata  = fold_val;
        fill_val_d = fold_val;
        if (DW'(fill_idx_q) == deg - DW'(1)) begin
          front_d   = (DW'(sep) < deg) ? AW'(sep) : '0;
          rear_d    = '0;
          disc_d    = CW'(DISCARD_FACTOR * deg);
          rd_pend_d = 1'b0;
          state_d   = ST_DISC;
        end else begin
          fill_idx_d = fill_idx_q + AW'(1);
          state_d    = ST_MUL;
        end
      end
      ST_DISC: begin
        // one read issued and one write-back completed per cycle
        complete = rd_pend_q;
        issue    = (disc_q != '0);
        if (complete) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = sum_val;
        end
        if (issue) begin
          ram_re    = 1'b1;
          disc_d    = disc_q - CW'(1);
          front_d   = idx_inc(front_q, deg);
          rear_d    = idx_inc(rear_q, deg);
          wr_addr_d = front_q;
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (func_q == FUNC_RESEED) begin
            state_d = ST_SEED;
          end else if (act_q == TYPE_LCG) begin
            state_d = ST_LCG_RD;
          end else begin
            state_d = ST_DRAW_RD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAW_RD: begin
        issue     = 1'b1;
        ram_re    = 1'b1;
        front_d   = idx_inc(front_q, deg);
        rear_d    = idx_inc(rear_q, deg);
        wr_addr_d = front_q;
        state_d   = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        if (out_free) begin
          complete  = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = sum_val;
          m_valid_d = 1'b1;
          m_data_d  = sum_val[31:1];
          state_d   = ST_IDLE;
        end
      end
      ST_LCG_RD: begin
        ram_re      = 1'b1;
        ram_raddr_a = '0;
        state_d     = ST_LCG_MUL;
      end
      ST_LCG_MUL: begin
        actl.mul_en  = 1'b1;
        actl.sel_lcg = 1'b1;
        state_d      = ST_LCG_ADD;
      end
      ST_LCG_ADD: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, lcg_val};
          m_valid_d = 1'b1;
          m_data_d  = lcg_val;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a read that hits this cycle's write-back sees the old word: forward
    if (issue) begin
      fwd_a_d    = complete && (front_q == wr_addr_q);
      fwd_b_d    = complete && (rear_q == wr_addr_q);
      fwd_data_d = sum_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_type_q <= 3'd3;
      act_q        <= 3'd3;
      seeded_q     <= 1'b0;
      pend_q       <= 1'b0;
      fill_idx_q   <= '0;
      front_q      <= AW'(3);
      rear_q       <= '0;
      disc_q       <= '0;
      rd_pend_q    <= 1'b0;
      fwd_a_q      <= 1'b0;
      fwd_b_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      table_type_q <= table_type_d;
      act_q        <= act_d;
      seeded_q     <= seeded_d;
      pend_q       <= pend_d;
      fill_idx_q   <= fill_idx_d;
      front_q      <= front_d;
      rear_q       <= rear_d;
      disc_q       <= disc_d;
      rd_pend_q    <= rd_pend_d;
      fwd_a_q      <= fwd_a_d;
      fwd_b_q      <= fwd_b_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    seed_q     <= seed_d;
    fill_val_q <= fill_val_d;
    wr_addr_q  <= wr_addr_d;
    fwd_data_q <= fwd_data_d;
    m_data_q   <= m_data_d;
  end

  afrg_lag_ram #(
    .DEPTH (MAX_DEGREE),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (rear_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  afrg_arith u_arith (
    .clk_i      (clk_i),
    .ctrl_i     (actl),
    .fill_val_i (fill_val_q),
    .rdata_a_i  (rdata_a),
    .rdata_b_i  (rdata_b),
    .fwd_data_i (fwd_data_q),
    .fold_o     (fold_val),
    .lcg_o      (lcg_val),
    .sum_o      (sum_val)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_data_q};

endmodule

[rtl/core/afrg_checker.sv]
// ----------------------------------------------------------------------------
// afrg_checker
// Port-level checks for the additive feedback random generator.
// ----------------------------------------------------------------------------
module afrg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // waiting input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i))
    else $error("input word changed while waiting");

  // values are 31 bits wide
  a_top_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("output word has bit 31 set");

  // one word at a time: busy after each accepted word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

  // no result can appear the cycle after a word is accepted
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

endmodule

bind additive_feedback_random_generator afrg_checker u_afrg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[verif/additive_feedback_random_generator_test.sv]
// ----------------------------------------------------------------------------
// additive_feedback_random_generator_test
// Self-checking bench for the additive feedback random generator: a short
// table of directed draws and reseeds over every table type, then random
// draw/reseed traffic with sender and receiver idling, scored word by word
// against a behavioural copy of the generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module additive_feedback_random_generator_test;
  import afrg_pkg::FUNC_DRAW;
  import afrg_pkg::FUNC_RESEED;
  import afrg_pkg::TYPE_LCG;
  import afrg_pkg::TYPE_MAX;

  localparam int TABLE_WORDS    = 63;
  // covers the longest reseed, with a margin on top
  localparam int SETTLE_CYCLES  = 800;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SEGMENT_WORDS  = 150;

  localparam logic [2:0] TT_DEG7   = 3'd1;
  localparam logic [2:0] TT_DEG15  = 3'd2;
  localparam logic [2:0] TT_DEG31  = 3'd3;
  localparam logic [2:0] TT_DEG63  = TYPE_MAX;
  localparam logic [2:0] TT_OVER5  = 3'd5;
  localparam logic [2:0] TT_OVER6  = 3'd6;
  localparam logic [2:0] TT_OVER7  = 3'd7;

  localparam logic [31:0] LCG_A     = 32'd1103515245;
  localparam logic [31:0] LCG_C     = 32'd12345;
  localparam logic [63:0] PARK_MUL  = 64'd16807;
  localparam logic [63:0] PARK_MOD  = 64'd2147483647;

  typedef enum logic { ROW_SET_TYPE, ROW_WORD } row_kind_e;
  typedef enum logic [1:0] { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_e;

  typedef struct {
    row_kind_e   kind;
    logic        func;
    logic [31:0] arg;     // seed for a word, table type for a type write
    bit          typed;   // value below is known by hand
    logic [30:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = FUNC_DRAW;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b1;
  logic [31:0] m_axis_tdata_o;

  // hand-computed value travelling alongside the word on the input
  bit          typed_pending = 1'b0;
  logic [30:0] typed_value = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int failures = 0;

  logic [30:0] expected_values [$];

  // generator copy
  bit [31:0] lag_words [TABLE_WORDS] = '{default: '0};
  int        head_idx = 3;
  int        tail_idx = 0;
  bit        is_seeded = 1'b0;
  bit [2:0]  requested_type = 3'd3;
  bit [2:0]  active_type = 3'd3;

  always #10 clk = ~clk;

  additive_feedback_random_generator i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic int degree_for(input bit [2:0] t);
    case (t)
      3'd0:    return 0;
      3'd1:    return 7;
      3'd2:    return 15;
      3'd3:    return 31;
      default: return 63;
    endcase
  endfunction

  function automatic int separation_for(input bit [2:0] t);
    case (t)
      3'd0:    return 0;
      3'd1:    return 3;
      3'd2:    return 1;
      3'd3:    return 3;
      default: return 1;
    endcase
  endfunction

  function automatic bit [30:0] draw_value();
    int        deg;
    bit [31:0] sum;
    if (active_type == TYPE_LCG) begin
      lag_words[0] = (LCG_A * lag_words[0] + LCG_C) & 32'h7fff_ffff;
      return lag_words[0][30:0];
    end
    deg = degree_for(active_type);
    if (head_idx >= deg) head_idx = 0;
    if (tail_idx >= deg) tail_idx = 0;
    sum = lag_words[head_idx] + lag_words[tail_idx];
    lag_words[head_idx] = sum;
    head_idx = (head_idx + 1 >= deg) ? 0 : head_idx + 1;
    tail_idx = (tail_idx + 1 >= deg) ? 0 : tail_idx + 1;
    return sum[31:1];
  endfunction

  function automatic void reseed_table(input bit [31:0] seed);
    int        deg;
    bit [63:0] prod;
    active_type = (requested_type > TYPE_MAX) ? TYPE_MAX : requested_type;
    lag_words[0] = (seed == 0) ? 32'd1 : seed;
    if (active_type == TYPE_LCG) return;
    deg = degree_for(active_type);
    for (int i = 1; i < deg; i++) begin
      prod = lag_words[i - 1] * PARK_MUL;
      lag_words[i] = 32'(prod % PARK_MOD);
    end
    head_idx = separation_for(active_type);
    tail_idx = 0;
    repeat (10 * deg) void'(draw_value());
  endfunction

  function automatic void predict_word(input logic func, input logic [31:0] seed,
                                       output bit produces, output logic [30:0] value);
    // the block reseeds itself with seed one ahead of its first word
    if (!is_seeded) begin
      reseed_table(32'd1);
      is_seeded = 1'b1;
    end
    produces = (func == FUNC_DRAW);
    value = '0;
    if (func == FUNC_RESEED) reseed_table(seed);
    else value = draw_value();
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    if (failures < 10) $display("mismatch: %s, expected %h, got %h", what, want, got);
    failures++;
  endfunction

  // scoreboard: outputs scored before the input accepted on the same edge is predicted
  always @(posedge clk) begin : monitor
    logic [30:0] want;
    bit          produces;
    logic [30:0] predicted;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_values.size() == 0) begin
          note_failure("word with nothing expected", '0, m_axis_tdata_o);
        end else begin
          want = expected_values.pop_front();
          if (m_axis_tdata_o !== {1'b0, want})
            note_failure("random_value", {1'b0, want}, m_axis_tdata_o);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_word(s_axis_tuser_i, s_axis_tdata_i, produces, predicted);
        if (produces) expected_values.push_back(typed_pending ? typed_value : predicted);
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready_i <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // all tasks below start and end on a falling edge
  task automatic send_word(input logic func, input logic [31:0] arg,
                           input bit typed, input logic [30:0] value);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = arg;
    typed_pending   = typed;
    typed_value     = value;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain(input bit settle);
    s_axis_tvalid_i = 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
    // a trailing reseed leaves nothing to wait for but still keeps the block busy
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_type(input logic [2:0] t);
    drain(1'b1);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = t;
    @(negedge clk);
    cfg_we_i = 1'b0;
    requested_type = t;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 46; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 46; end
      default:       begin src_idle_pct = 29; sink_stall_pct = 29; end
    endcase
  endtask

  row_t directed_rows [29] = '{
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},  // first word after reset
    '{ROW_WORD,     FUNC_DRAW,   32'hffff_ffff, 1'b0, '0},
    '{ROW_WORD,     FUNC_RESEED, 32'h0000_0000, 1'b0, '0},  // zero seed reads as one
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TYPE_LCG), 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},  // new type not yet active
    '{ROW_WORD,     FUNC_RESEED, 32'h0000_0001, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b1, 31'd1103527590},
    '{ROW_WORD,     FUNC_RESEED, 32'h0000_0000, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b1, 31'd1103527590},
    '{ROW_WORD,     FUNC_RESEED, 32'hffff_ffff, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b1, 31'd1043980748},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TT_DEG7),  1'b0, '0},
    '{ROW_WORD,     FUNC_RESEED, 32'h7fff_ffff, 1'b0, '0},  // fill beyond the seed word collapses to zeros
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TT_DEG15), 1'b0, '0},
    '{ROW_WORD,     FUNC_RESEED, 32'h8000_0000, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TT_OVER7), 1'b0, '0},  // out of range, acts as 63
    '{ROW_WORD,     FUNC_RESEED, 32'hffff_ffff, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h5555_aaaa, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TT_DEG63), 1'b0, '0},
    '{ROW_WORD,     FUNC_RESEED, 32'h0000_3039, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0},
    '{ROW_SET_TYPE, FUNC_DRAW,   32'(TT_DEG31), 1'b0, '0},
    '{ROW_WORD,     FUNC_RESEED, 32'h0000_0000, 1'b0, '0},
    '{ROW_WORD,     FUNC_DRAW,   32'h0000_0000, 1'b0, '0}
  };

  logic [2:0] segment_types [8] = '{TT_DEG63, TYPE_LCG, TT_DEG7, TT_OVER7,
                                    TT_DEG15, TT_DEG31, TT_OVER5, TT_OVER6};

  initial begin : stimulus
    logic [31:0] seed;
    repeat (4) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    set_idle(IDLE_NONE);
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SET_TYPE)
        write_type(directed_rows[r].arg[2:0]);
      else
        send_word(directed_rows[r].func, directed_rows[r].arg,
                  directed_rows[r].typed, directed_rows[r].value);
    end

    for (int seg = 0; seg < 8; seg++) begin
      set_idle(idle_mode_e'(seg % 4));
      write_type(segment_types[seg]);
      send_word(FUNC_RESEED, $urandom, 1'b0, '0);  // makes the new type active
      for (int n = 1; n < SEGMENT_WORDS; n++) begin
        if (n == SEGMENT_WORDS / 2) drain(1'b0);
        if ($urandom_range(99) < 3) begin
          seed = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
          send_word(FUNC_RESEED, seed, 1'b0, '0);
        end else begin
          send_word(FUNC_DRAW, $urandom, 1'b0, '0);
        end
      end
    end

    drain(1'b1);
    if (expected_values.size() != 0)
      note_failure("words never delivered", '0, expected_values.size());
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/afrg_pkg.sv
rtl/core/afrg_lag_ram.sv
rtl/core/afrg_arith.sv
rtl/core/additive_feedback_random_generator.sv
rtl/core/afrg_checker.sv
verif/additive_feedback_random_generator_test.sv
